/* hdl/jfcm_pkg.sv */
// Shared constants, types and codes of the jet false-color mapper.
package jfcm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int CH_BITS        = 8;
    localparam int QUO_BITS       = CH_BITS;
    localparam int PROD_BITS      = SAMPLE_BITS + CH_BITS;
    localparam int Q_BITS         = SAMPLE_BITS + 2;
    localparam int TDATA_IN_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_BITS = 3 * CH_BITS;

    localparam logic [CH_BITS-1:0] CH_FULL = {CH_BITS{1'b1}};
    localparam logic [CH_BITS-1:0] CH_ZERO = {CH_BITS{1'b0}};

    localparam logic [0:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [0:0] REG_RANGE_HIGH = 1'b1;

    typedef enum logic [1:0] {
        SEG_GREEN_UP,
        SEG_BLUE_DOWN,
        SEG_RED_UP,
        SEG_GREEN_DOWN
    } seg_t;

    typedef struct packed {
        logic [PROD_BITS-1:0]   rem;
        logic [SAMPLE_BITS-1:0] dv;
        logic [QUO_BITS-1:0]    quo;
        seg_t                   seg;
        logic                   inv;
    } div_item_t;

endpackage

/* hdl/jfcm_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module jfcm_div
    import jfcm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_item
);

    div_item_t           stage_reg [QUO_BITS];
    logic [QUO_BITS-1:0] valid_reg;
    logic [QUO_BITS-1:0] ready;

    always_comb begin
        for (int k = 0; k < QUO_BITS; k++) begin
            ready[k] = !valid_reg[k];
        end
        ready[QUO_BITS-1] = !valid_reg[QUO_BITS-1] || out_ready;
        for (int k = QUO_BITS - 2; k >= 0; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[QUO_BITS-1];
    assign out_item  = stage_reg[QUO_BITS-1];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        div_item_t            prev;
        logic                 prev_valid;
        logic [PROD_BITS-1:0] trial;
        div_item_t            stage_next;

        if (k == 0) begin : g_first
            assign prev       = in_item;
            assign prev_valid = in_valid;
        end else begin : g_rest
            assign prev       = stage_reg[k-1];
            assign prev_valid = valid_reg[k-1];
        end

        always_comb begin
            trial      = PROD_BITS'(prev.dv) << (QUO_BITS - 1 - k);
            stage_next = prev;
            if (prev.rem >= trial) begin
                stage_next.rem                  = prev.rem - trial;
                stage_next.quo[QUO_BITS-1-k]    = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ready[k]) begin
                valid_reg[k] <= prev_valid;
            end
            if (ready[k] && prev_valid) begin
                stage_reg[k] <= stage_next;
            end
        end
    end

    a_last_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[QUO_BITS-1] && !out_ready |=> valid_reg[QUO_BITS-1]
            && $stable(stage_reg[QUO_BITS-1]))
        else $error("divider output changed while stalled");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[QUO_BITS-1] && !stage_reg[QUO_BITS-1].inv
            |-> stage_reg[QUO_BITS-1].rem < PROD_BITS'(stage_reg[QUO_BITS-1].dv))
        else $error("divider remainder not below divisor");

    a_blocked_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> &valid_reg && !out_ready)
        else $error("divider input blocked while a stage is free");

endmodule

/* hdl/jet_false_color_map_core.sv */
// Top level of the jet false-color mapper: range setup, segment selection and output register.
//
// Each transaction on the s_ channel carries one unsigned sample; each transaction on
// the m_ channel carries its color as red, green and blue bytes plus a range_invalid flag.
// The sample is clamped to [range_low, range_high] and colored along the jet scale
// blue, cyan, green, yellow, red. When range_high is not above range_low the color is
// pure red and range_invalid is set.
// range_low and range_high are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while no sample is in flight, as the block does not enforce this; they
// reset to zero and to all ones. From an accepted sample to its result there are four
// stages for clamping, segment selection and scaling, eight stages of the pipelined divider
// that produces one bit of the channel value each, and the output register.
// One sample is accepted per cycle while s_tready is high; each stage holds its own valid bit.
// When the receiver stalls, results stay in the output register and the stages
// behind it keep filling until the pipeline is full, then s_tready falls.
// Reset empties the pipeline and drops any result not yet taken.
module jet_false_color_map_core
    import jfcm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [SAMPLE_BITS-1:0]    cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [TDATA_IN_BITS-1:0]  s_tdata,   // sample
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [TDATA_OUT_BITS-1:0] m_tdata,   // red, green, blue
    output logic                      m_tuser    // range_invalid
);

    logic [SAMPLE_BITS-1:0] range_low_reg;
    logic [SAMPLE_BITS-1:0] range_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= '0;
            range_high_reg <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                REG_RANGE_HIGH: range_high_reg <= cfg_data;
                default:        range_low_reg  <= range_low_reg;
            endcase
        end
    end

    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;
    logic div_in_ready, div_out_valid;
    div_item_t div_out_item;

    assign rdy_out  = !vo_reg || m_tready;
    assign rdy4     = !v4_reg || div_in_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // Stage 1: clamp, offset and span.
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] clamped;
    logic [SAMPLE_BITS-1:0] d1_reg, dv1_reg, d1_next, dv1_next;
    logic                   inv1_reg, inv1_next;

    assign sample = s_tdata[SAMPLE_BITS-1:0];

    always_comb begin
        if (sample < range_low_reg) begin
            clamped = range_low_reg;
        end else if (sample > range_high_reg) begin
            clamped = range_high_reg;
        end else begin
            clamped = sample;
        end
        d1_next   = clamped - range_low_reg;
        dv1_next  = range_high_reg - range_low_reg;
        inv1_next = range_high_reg <= range_low_reg;
    end

    // Stage 2: scaled offset and quarter boundaries.
    logic [Q_BITS-1:0]      q2_reg, dv2x_reg, dv3x_reg;
    logic [SAMPLE_BITS-1:0] dv2_reg;
    logic                   inv2_reg;

    // Stage 3: segment and ramp numerator.
    logic [SAMPLE_BITS-1:0] num3_reg, dv3_reg, num3_next;
    seg_t                   seg3_reg, seg3_next;
    logic                   inv3_reg;
    logic [Q_BITS-1:0]      dv_ext;
    logic [Q_BITS-1:0]      num_wide;

    always_comb begin
        dv_ext = Q_BITS'(dv2_reg);
        if (q2_reg < dv_ext) begin
            seg3_next = SEG_GREEN_UP;
            num_wide  = q2_reg;
        end else if (q2_reg < dv2x_reg) begin
            seg3_next = SEG_BLUE_DOWN;
            num_wide  = q2_reg - dv_ext;
        end else if (q2_reg < dv3x_reg) begin
            seg3_next = SEG_RED_UP;
            num_wide  = q2_reg - dv2x_reg;
        end else begin
            seg3_next = SEG_GREEN_DOWN;
            num_wide  = q2_reg - dv3x_reg;
        end
        num3_next = num_wide[SAMPLE_BITS-1:0];
    end

    // Stage 4: dividend 255 * numerator.
    div_item_t div4_reg, div4_next;

    always_comb begin
        div4_next.rem = (PROD_BITS'(num3_reg) << CH_BITS) - PROD_BITS'(num3_reg);
        div4_next.dv  = dv3_reg;
        div4_next.quo = '0;
        div4_next.seg = seg3_reg;
        div4_next.inv = inv3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
        if (rdy1 && s_tvalid) begin
            d1_reg   <= d1_next;
            dv1_reg  <= dv1_next;
            inv1_reg <= inv1_next;
        end
        if (rdy2 && v1_reg) begin
            q2_reg   <= Q_BITS'(d1_reg) << 2;
            dv2x_reg <= Q_BITS'(dv1_reg) << 1;
            dv3x_reg <= (Q_BITS'(dv1_reg) << 1) + Q_BITS'(dv1_reg);
            dv2_reg  <= dv1_reg;
            inv2_reg <= inv1_reg;
        end
        if (rdy3 && v2_reg) begin
            num3_reg <= num3_next;
            dv3_reg  <= dv2_reg;
            seg3_reg <= seg3_next;
            inv3_reg <= inv2_reg;
        end
        if (rdy4 && v3_reg) begin
            div4_reg <= div4_next;
        end
    end

    jfcm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v4_reg),
        .in_ready  (div_in_ready),
        .in_item   (div4_reg),
        .out_valid (div_out_valid),
        .out_ready (rdy_out),
        .out_item  (div_out_item)
    );

    // Output stage: channel assembly.
    logic [CH_BITS-1:0] ramp_up, ramp_down;
    logic [CH_BITS-1:0] red_next, green_next, blue_next;
    logic [CH_BITS-1:0] red_reg, green_reg, blue_reg;
    logic               inv_out_reg;

    always_comb begin
        ramp_up   = div_out_item.quo;
        ramp_down = CH_FULL - div_out_item.quo;
        case (div_out_item.seg)
            SEG_GREEN_UP: begin
                red_next   = CH_ZERO;
                green_next = ramp_up;
                blue_next  = CH_FULL;
            end
            SEG_BLUE_DOWN: begin
                red_next   = CH_ZERO;
                green_next = CH_FULL;
                blue_next  = ramp_down;
            end
            SEG_RED_UP: begin
                red_next   = ramp_up;
                green_next = CH_FULL;
                blue_next  = CH_ZERO;
            end
            default: begin
                red_next   = CH_FULL;
                green_next = ramp_down;
                blue_next  = CH_ZERO;
            end
        endcase
        if (div_out_item.inv) begin
            red_next   = CH_FULL;
            green_next = CH_ZERO;
            blue_next  = CH_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (rdy_out) begin
            vo_reg <= div_out_valid;
        end
        if (rdy_out && div_out_valid) begin
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            inv_out_reg <= div_out_item.inv;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};
    assign m_tuser  = inv_out_reg;

    a_invalid_is_red: assert property (@(posedge aclk) disable iff (!aresetn)
        vo_reg && inv_out_reg |-> red_reg == CH_FULL && green_reg == CH_ZERO
            && blue_reg == CH_ZERO)
        else $error("invalid range result is not pure red");

    a_red_blue_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        vo_reg |-> red_reg == CH_ZERO || blue_reg == CH_ZERO)
        else $error("red and blue both lit");

    a_one_channel_full: assert property (@(posedge aclk) disable iff (!aresetn)
        vo_reg |-> red_reg == CH_FULL || green_reg == CH_FULL || blue_reg == CH_FULL)
        else $error("no channel at full intensity");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && v3_reg && v4_reg && !div_in_ready |-> !s_tready)
        else $error("input accepted while front stages are full and blocked");

endmodule
